[rtl/core/slca_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the status LED color animator.
// No dependencies; used by the interfaces and every module of the block.
package slca_pkg;

   localparam int TIME_W  = 12;
   localparam int CHAN_W  = 8;
   localparam int MODE_W  = 2;
   localparam int PROD_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_ARMED   = 2'd0,
      MODE_RX_LOST = 2'd1,
      MODE_IDLE    = 2'd2
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_LED_PRESENT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_INSTALLED = 2'd1;

   localparam logic [CHAN_W-1:0] ARMED_R = 8'hFF;
   localparam logic [CHAN_W-1:0] ARMED_G = 8'h18;
   localparam logic [CHAN_W-1:0] AMBER_R = 8'hFF;
   localparam logic [CHAN_W-1:0] AMBER_G = 8'h70;

   localparam logic [CHAN_W-1:0] ARMED_BASE = 8'd48;
   localparam logic [CHAN_W-1:0] ARMED_SPAN = 8'd176;
   localparam logic [CHAN_W-1:0] AMBER_BASE = 8'd24;
   localparam logic [CHAN_W-1:0] AMBER_SPAN = 8'd140;
   localparam logic [CHAN_W-1:0] IDLE_BASE  = 8'd36;
   localparam logic [CHAN_W-1:0] IDLE_SPAN  = 8'd156;

   localparam logic [CHAN_W-1:0] WHEEL_SEG1 = 8'd85;
   localparam logic [CHAN_W-1:0] WHEEL_SEG2 = 8'd170;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   typedef struct packed {
      color_type         color;
      logic [CHAN_W-1:0] level;
      mode_type          mode;
   } lvl_item_type;

   typedef struct packed {
      color_type color;
      mode_type  mode;
   } pix_item_type;

   // 8-bit triangle wave
   function automatic logic [CHAN_W-1:0] tri_wave(input logic [CHAN_W-1:0] v);
      logic [CHAN_W-1:0] low;
      low = {v[6:0], 1'b0};
      return v[7] ? (8'hFF - low) : low;
   endfunction

   // floor(x / 255), exact for x up to 255 * 255
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] s;
      s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return s[15:8];
   endfunction

   // color wheel lookup from an 8-bit hue
   function automatic color_type wheel(input logic [CHAN_W-1:0] hue);
      logic [CHAN_W-1:0] p;
      logic [CHAN_W-1:0] q;
      logic [CHAN_W+1:0] q3;
      color_type c;
      p  = ~hue;
      q  = p;
      if (p >= WHEEL_SEG2) begin
         q = p - WHEEL_SEG2;
      end else if (p >= WHEEL_SEG1) begin
         q = p - WHEEL_SEG1;
      end
      q3 = {2'b00, q} + {1'b0, q, 1'b0};
      if (p < WHEEL_SEG1) begin
         c.red   = 8'hFF - q3[7:0];
         c.green = '0;
         c.blue  = q3[7:0];
      end else if (p < WHEEL_SEG2) begin
         c.red   = '0;
         c.green = q3[7:0];
         c.blue  = 8'hFF - q3[7:0];
      end else begin
         c.red   = q3[7:0];
         c.green = 8'hFF - q3[7:0];
         c.blue  = '0;
      end
      return c;
   endfunction

endpackage

[rtl/core/slca_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: item request, color response and register write port.
// Depends on slca_pkg for field widths.
interface slca_req_if;
   logic                          valid;
   logic                          ready;
   logic [slca_pkg::TIME_W-1:0]   time_ms;
   logic                          armed;
   logic                          rx_connected;
   modport source(output valid, output time_ms, output armed, output rx_connected,
                  input ready);
   modport sink(input valid, input time_ms, input armed, input rx_connected,
                output ready);
endinterface

interface slca_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [slca_pkg::CHAN_W-1:0]   red;
   logic [slca_pkg::CHAN_W-1:0]   green;
   logic [slca_pkg::CHAN_W-1:0]   blue;
   logic [slca_pkg::MODE_W-1:0]   mode;
   modport source(output valid, output red, output green, output blue, output mode,
                  input ready);
   modport sink(input valid, input red, input green, input blue, input mode,
                output ready);
endinterface

interface slca_csr_if;
   logic                              valid;
   logic                              ready;
   logic [slca_pkg::CSR_IDX_W-1:0]    index;
   logic [slca_pkg::CSR_DATA_W-1:0]   wdata;
   modport source(output valid, output index, output wdata, input ready);
   modport sink(input valid, input index, input wdata, output ready);
endinterface

[rtl/core/slca_env_stage.sv]
`timescale 1ns / 1ps
// Stages 1-2: mode select, base color, triangle envelope and brightness level.
// Depends on slca_pkg.
module slca_env_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [slca_pkg::TIME_W-1:0]   time_ms,
   input  logic                          armed,
   input  logic                          rx_connected,
   input  logic                          rx_installed,
   output logic                          out_valid,
   input  logic                          out_ready,
   output slca_pkg::lvl_item_type        out_item
);

   logic                             s1_en;
   logic                             s2_en;
   logic                             s1_v_ff;
   logic                             s2_v_ff;
   slca_pkg::mode_type               s1_mode_in;
   slca_pkg::mode_type               s1_mode_ff;
   slca_pkg::color_type              s1_color_in;
   slca_pkg::color_type              s1_color_ff;
   logic [slca_pkg::CHAN_W-1:0]      s1_base_in;
   logic [slca_pkg::CHAN_W-1:0]      s1_base_ff;
   logic [slca_pkg::CHAN_W-1:0]      span;
   logic [slca_pkg::CHAN_W-1:0]      phase;
   logic [slca_pkg::PROD_W-1:0]      s1_prod_in;
   logic [slca_pkg::PROD_W-1:0]      s1_prod_ff;
   slca_pkg::lvl_item_type           s2_item_in;
   slca_pkg::lvl_item_type           s2_item_ff;

   assign s2_en    = !s2_v_ff || out_ready;
   assign s1_en    = !s1_v_ff || s2_en;
   assign in_ready = s1_en;

   always_comb begin
      if (armed) begin
         s1_mode_in  = slca_pkg::MODE_ARMED;
         s1_color_in = '{slca_pkg::ARMED_R, slca_pkg::ARMED_G, 8'd0};
         s1_base_in  = slca_pkg::ARMED_BASE;
         span        = slca_pkg::ARMED_SPAN;
         phase       = time_ms[9:2];
      end else if (rx_installed && !rx_connected) begin
         s1_mode_in  = slca_pkg::MODE_RX_LOST;
         s1_color_in = '{slca_pkg::AMBER_R, slca_pkg::AMBER_G, 8'd0};
         s1_base_in  = slca_pkg::AMBER_BASE;
         span        = slca_pkg::AMBER_SPAN;
         phase       = time_ms[10:3];
      end else begin
         s1_mode_in  = slca_pkg::MODE_IDLE;
         s1_color_in = slca_pkg::wheel(time_ms[11:4]);
         s1_base_in  = slca_pkg::IDLE_BASE;
         span        = slca_pkg::IDLE_SPAN;
         phase       = time_ms[10:3];
      end
      s1_prod_in = slca_pkg::tri_wave(phase) * span;
   end

   always_comb begin
      s2_item_in.color = s1_color_ff;
      s2_item_in.mode  = s1_mode_ff;
      s2_item_in.level = s1_base_ff + slca_pkg::div255(s1_prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_v_ff <= in_valid;
         end
         if (s2_en) begin
            s2_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_mode_ff  <= s1_mode_in;
         s1_color_ff <= s1_color_in;
         s1_base_ff  <= s1_base_in;
         s1_prod_ff  <= s1_prod_in;
      end
      if (s2_en) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_item  = s2_item_ff;

endmodule

[rtl/core/slca_scale_stage.sv]
`timescale 1ns / 1ps
// Stages 3-4: scale each color channel by the brightness level, divide by 255.
// Depends on slca_pkg; the last stage is the response output register.
module slca_scale_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  slca_pkg::lvl_item_type   in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output slca_pkg::pix_item_type   out_item
);

   logic                          s3_en;
   logic                          s4_en;
   logic                          s3_v_ff;
   logic                          s4_v_ff;
   logic [slca_pkg::PROD_W-1:0]   s3_r_in;
   logic [slca_pkg::PROD_W-1:0]   s3_g_in;
   logic [slca_pkg::PROD_W-1:0]   s3_b_in;
   logic [slca_pkg::PROD_W-1:0]   s3_r_ff;
   logic [slca_pkg::PROD_W-1:0]   s3_g_ff;
   logic [slca_pkg::PROD_W-1:0]   s3_b_ff;
   slca_pkg::mode_type            s3_mode_ff;
   slca_pkg::pix_item_type        s4_item_in;
   slca_pkg::pix_item_type        s4_item_ff;

   assign s4_en    = !s4_v_ff || out_ready;
   assign s3_en    = !s3_v_ff || s4_en;
   assign in_ready = s3_en;

   assign s3_r_in = in_item.color.red   * in_item.level;
   assign s3_g_in = in_item.color.green * in_item.level;
   assign s3_b_in = in_item.color.blue  * in_item.level;

   always_comb begin
      s4_item_in.color.red   = slca_pkg::div255(s3_r_ff);
      s4_item_in.color.green = slca_pkg::div255(s3_g_ff);
      s4_item_in.color.blue  = slca_pkg::div255(s3_b_ff);
      s4_item_in.mode        = s3_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s3_en) begin
            s3_v_ff <= in_valid;
         end
         if (s4_en) begin
            s4_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_r_ff    <= s3_r_in;
         s3_g_ff    <= s3_g_in;
         s3_b_ff    <= s3_b_in;
         s3_mode_ff <= in_item.mode;
      end
      if (s4_en) begin
         s4_item_ff <= s4_item_in;
      end
   end

   assign out_valid = s4_v_ff;
   assign out_item  = s4_item_ff;

endmodule

[rtl/core/status_led_color_animator_unit.sv]
`timescale 1ns / 1ps
// Top level of the status LED color animator: register port and four-stage pipeline.
// Depends on slca_pkg, slca_if, slca_env_stage and slca_scale_stage.
//
// Usage: each transfer on req_bus carries a 12-bit millisecond time stamp and the
// armed and receiver-connected flags. Each accepted item yields one transfer on
// rsp_bus holding red, green, blue and the mode (armed heartbeat, receiver lost
// amber, idle hue cycle). While led_present is clear, items are accepted and
// dropped without a response. csr_bus writes led_present (index 0) and
// rx_installed (index 1); other indexes are ignored. csr_bus is always ready;
// write it only while the pipeline is empty.
// Pipeline: rsp_bus.valid rises once the item has passed four register
// stages: mode and envelope product, brightness level, channel products, divide
// by 255.
// Throughput: one item per cycle while rsp_bus.ready is high; every stage advances whenever the next one moves.
// Reset: clears all stage valid bits, sets led_present to 1 and rx_installed to 0.
// Stall: when rsp_bus.ready is low the response holds and the stages fill up;
// req_bus.ready drops only once every stage holds an item. Nothing is lost.
module status_led_color_animator_unit (
   input  logic        clock,
   input  logic        reset,
   slca_req_if.sink    req_bus,
   slca_rsp_if.source  rsp_bus,
   slca_csr_if.sink    csr_bus
);

   logic                     led_present_ff;
   logic                     rx_installed_ff;
   logic                     env_in_valid;
   logic                     env_in_ready;
   logic                     lvl_valid;
   logic                     lvl_ready;
   slca_pkg::lvl_item_type   lvl_item;
   slca_pkg::pix_item_type   pix_item;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_present_ff  <= 1'b1;
         rx_installed_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            slca_pkg::CSR_LED_PRESENT: begin
               led_present_ff <= csr_bus.wdata[0];
            end
            slca_pkg::CSR_RX_INSTALLED: begin
               rx_installed_ff <= csr_bus.wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // drop items while no LED is fitted
   assign env_in_valid  = req_bus.valid && led_present_ff;
   assign req_bus.ready = env_in_ready || !led_present_ff;

   slca_env_stage u_env (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (env_in_valid),
      .in_ready     (env_in_ready),
      .time_ms      (req_bus.time_ms),
      .armed        (req_bus.armed),
      .rx_connected (req_bus.rx_connected),
      .rx_installed (rx_installed_ff),
      .out_valid    (lvl_valid),
      .out_ready    (lvl_ready),
      .out_item     (lvl_item)
   );

   slca_scale_stage u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lvl_valid),
      .in_ready  (lvl_ready),
      .in_item   (lvl_item),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (pix_item)
   );

   assign rsp_bus.red   = pix_item.color.red;
   assign rsp_bus.green = pix_item.color.green;
   assign rsp_bus.blue  = pix_item.color.blue;
   assign rsp_bus.mode  = pix_item.mode;

endmodule

[rtl/core/slca_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the response channel of the status LED color animator.
// Depends on slca_pkg; bound to status_led_color_animator_unit below.
module slca_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [slca_pkg::CHAN_W-1:0]   rsp_red,
   input logic [slca_pkg::CHAN_W-1:0]   rsp_green,
   input logic [slca_pkg::CHAN_W-1:0]   rsp_blue,
   input logic [slca_pkg::MODE_W-1:0]   rsp_mode
);

   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_mode))
      else $error("stalled response changed");

   a_warm_no_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == slca_pkg::MODE_ARMED || rsp_mode == slca_pkg::MODE_RX_LOST)
         |-> rsp_blue == '0 && rsp_red >= rsp_green)
      else $error("warning color out of shape");

   a_wheel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == slca_pkg::MODE_IDLE
         |-> rsp_red == '0 || rsp_green == '0 || rsp_blue == '0)
      else $error("hue color without a dark channel");

endmodule

bind status_led_color_animator_unit slca_checker u_slca_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_red   (rsp_bus.red),
   .rsp_green (rsp_bus.green),
   .rsp_blue  (rsp_bus.blue),
   .rsp_mode  (rsp_bus.mode)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for status_led_color_animator_unit: drives time stamps and status flags,
// predicts every color and mode, and compares each response field by field.
// Depends on slca_pkg, slca_if and the status LED color animator RTL.
module tb;
   import slca_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_COUNT    = 6;
   localparam int LIT_ITEMS      = 244;
   localparam int DARK_ITEMS     = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam bit [PHASE_COUNT-1:0] LED_PLAN = 6'b101011;
   localparam bit [PHASE_COUNT-1:0] RX_PLAN  = 6'b011010;

   logic clock;
   logic reset;

   slca_req_if req_bus();
   slca_rsp_if rsp_bus();
   slca_csr_if csr_bus();

   status_led_color_animator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pix_item_type pending_colors[$];

   bit led_on;
   bit rx_fitted;
   bit req_calm;
   bit rsp_calm;
   int mismatches;
   int colors_seen;
   int items_sent;
   int reg_writes;
   int quiet_cycles;
   int mode_hits[3];

   function automatic int unsigned triangle(input logic [7:0] v);
      int unsigned low;
      low = {v[6:0], 1'b0};
      return v[7] ? 255 - low : low;
   endfunction

   function automatic int unsigned envelope(input int unsigned base, input int unsigned span,
                                            input logic [7:0] phase);
      return base + (triangle(phase) * span) / 255;
   endfunction

   function automatic pix_item_type predict_color(input logic [TIME_W-1:0] stamp,
                                                  input logic armed, input logic linked);
      int unsigned r;
      int unsigned g;
      int unsigned b;
      int unsigned lvl;
      int unsigned p;
      pix_item_type c;
      if (armed) begin
         c.mode = MODE_ARMED;
         r = ARMED_R;
         g = ARMED_G;
         b = 0;
         lvl = envelope(ARMED_BASE, ARMED_SPAN, stamp[9:2]);
      end else if (rx_fitted && !linked) begin
         c.mode = MODE_RX_LOST;
         r = AMBER_R;
         g = AMBER_G;
         b = 0;
         lvl = envelope(AMBER_BASE, AMBER_SPAN, stamp[10:3]);
      end else begin
         c.mode = MODE_IDLE;
         p = 255 - int'(stamp[11:4]);
         if (p < 85) begin
            r = 255 - 3 * p;
            g = 0;
            b = 3 * p;
         end else if (p < 170) begin
            p = p - 85;
            r = 0;
            g = 3 * p;
            b = 255 - 3 * p;
         end else begin
            p = p - 170;
            r = 3 * p;
            g = 255 - 3 * p;
            b = 0;
         end
         lvl = envelope(IDLE_BASE, IDLE_SPAN, stamp[10:3]);
      end
      c.color.red   = 8'((r * lvl) / 255);
      c.color.green = 8'((g * lvl) / 255);
      c.color.blue  = 8'((b * lvl) / 255);
      return c;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int stall;
         stall = rsp_calm ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      pix_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         colors_seen++;
         if (rsp_bus.mode < 3) mode_hits[rsp_bus.mode]++;
         if (pending_colors.size() == 0) begin
            $display("%0t ns: unexpected color, expected none, actual r=%0d g=%0d b=%0d mode=%0d",
                     $time, rsp_bus.red, rsp_bus.green, rsp_bus.blue, rsp_bus.mode);
            mismatches++;
         end else begin
            want = pending_colors.pop_front();
            check_field("red", want.color.red, rsp_bus.red);
            check_field("green", want.color.green, rsp_bus.green);
            check_field("blue", want.color.blue, rsp_bus.blue);
            check_field("mode", want.mode, rsp_bus.mode);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t ns: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_status(input logic [TIME_W-1:0] stamp, input logic armed,
                              input logic linked);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.time_ms      <= stamp;
      req_bus.armed        <= armed;
      req_bus.rx_connected <= linked;
      req_bus.valid        <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      if (led_on) pending_colors.push_back(predict_color(stamp, armed, linked));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_LED_PRESENT) begin
         led_on = value;
      end else if (idx == CSR_RX_INSTALLED) begin
         rx_fitted = value;
      end
      reg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic settle_pipeline;
      if (req_bus.valid) req_bus.valid <= 1'b0;
      while (pending_colors.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic test_default_config;
      send_status(12'd0, 1'b1, 1'b0);
      send_status(12'hFFF, 1'b1, 1'b1);
      send_status(12'd0, 1'b0, 1'b0);
      send_status(12'hFFF, 1'b0, 1'b1);
      send_status(12'h555, 1'b1, 1'b0);
      send_status(12'hAAA, 1'b0, 1'b0);
      settle_pipeline();
   endtask

   task automatic test_mode_priority;
      write_reg(CSR_RX_INSTALLED, 1'b1);
      send_status(12'h3FC, 1'b1, 1'b0);
      send_status(12'h7F8, 1'b0, 1'b0);
      send_status(12'h800, 1'b0, 1'b1);
      send_status(12'hFFF, 1'b0, 1'b0);
      send_status(12'd0, 1'b0, 1'b0);
      settle_pipeline();
   endtask

   task automatic test_wheel_segments;
      logic [7:0] hues[6];
      hues = '{8'd0, 8'd85, 8'd86, 8'd170, 8'd171, 8'd255};
      foreach (hues[i]) send_status({hues[i], 4'(i * 3)}, 1'b0, 1'b1);
      settle_pipeline();
   endtask

   task automatic test_no_led;
      write_reg(CSR_LED_PRESENT, 1'b0);
      send_status(12'd0, 1'b1, 1'b0);
      send_status(12'hFFF, 1'b0, 1'b0);
      send_status(12'h123, 1'b0, 1'b1);
      settle_pipeline();
      write_reg(CSR_SPARE_A, 1'b1);
      write_reg(CSR_SPARE_B, 1'b1);
      send_status(12'h800, 1'b1, 1'b1);
      send_status(12'h7FF, 1'b0, 1'b0);
      settle_pipeline();
      write_reg(CSR_LED_PRESENT, 1'b1);
      write_reg(CSR_SPARE_B, 1'b0);
      write_reg(CSR_SPARE_A, 1'b0);
      send_status(12'h0F0, 1'b0, 1'b0);
      send_status(12'hF0F, 1'b1, 1'b0);
      settle_pipeline();
   endtask

   task automatic test_random_traffic;
      int count;
      logic [TIME_W-1:0] stamp;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_pipeline();
         if ($urandom_range(0, 1)) begin
            write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      1'($urandom_range(0, 1)));
         end
         write_reg(CSR_LED_PRESENT, LED_PLAN[phase]);
         write_reg(CSR_RX_INSTALLED, RX_PLAN[phase]);
         count = LED_PLAN[phase] ? LIT_ITEMS : DARK_ITEMS;
         for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
               req_calm = ($urandom_range(0, 3) == 0);
               rsp_calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 7) == 0) begin
               stamp = $urandom_range(0, 1) ? '1 : '0;
            end else begin
               stamp = 12'($urandom_range(0, 4095));
            end
            send_status(stamp, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
         end
      end
      settle_pipeline();
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.time_ms      = '0;
      req_bus.armed        = 1'b0;
      req_bus.rx_connected = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.wdata        = '0;
      led_on               = 1'b1;
      rx_fitted            = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_config();
      test_mode_priority();
      test_wheel_segments();
      test_no_led();
      test_random_traffic();
      settle_pipeline();

      $display("Sent %0d status items, checked %0d colors, %0d register writes",
               items_sent, colors_seen, reg_writes);
      $display("Colors by mode: armed %0d, receiver lost %0d, idle %0d",
               mode_hits[0], mode_hits[1], mode_hits[2]);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
